/* design/ecpa_pkg.sv */
// shared types, constants and field arithmetic helpers for the point adder
package ecpa_pkg;

  localparam int ELEM_W = 64;
  localparam int CNT_W  = $clog2(ELEM_W);
  localparam int CFG_AW = 4;

  typedef logic [ELEM_W-1:0] elem_t;

  typedef enum logic {
    OP_MUL,
    OP_RED
  } fop_e;

  typedef struct packed {
    logic start;
    fop_e op;
  } fu_ctl_t;

  localparam logic  REG_PRIME = 1'b0;
  localparam logic  REG_COEFF = 1'b1;
  localparam elem_t P_RESET   = elem_t'(64'hFFFF_FFFF_FFFF_FFC5);
  localparam elem_t ELEM_ZERO = elem_t'(0);
  localparam elem_t ELEM_ONE  = elem_t'(1);
  localparam elem_t ELEM_TWO  = elem_t'(2);

  function automatic elem_t fadd(elem_t a, elem_t b, elem_t m);
    logic [ELEM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[ELEM_W-1:0];
  endfunction

  function automatic elem_t fsub(elem_t a, elem_t b, elem_t m);
    elem_t r;
    if (a >= b) begin
      r = a - b;
    end else begin
      r = a + (m - b);
    end
    return r;
  endfunction

endpackage

/* design/ecpa_field_unit.sv */
// bit-serial modular multiplier and reducer, one operand bit shifted in per step
module ecpa_field_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ecpa_pkg::fu_ctl_t ctl_i,
  input  ecpa_pkg::elem_t   a_i,
  input  ecpa_pkg::elem_t   b_i,
  input  ecpa_pkg::elem_t   m_i,
  output logic              done_o,
  output ecpa_pkg::elem_t   res_o
);

  logic                       busy_q;
  logic                       done_q;
  logic                       phase_q;
  ecpa_pkg::fop_e             op_q;
  logic [ecpa_pkg::CNT_W-1:0] cnt_q;
  ecpa_pkg::elem_t            acc_q;
  ecpa_pkg::elem_t            a_q;
  ecpa_pkg::elem_t            sh_q;

  ecpa_pkg::elem_t            dbl;
  ecpa_pkg::elem_t            addv;
  logic [ecpa_pkg::ELEM_W:0]  rem;
  logic [ecpa_pkg::ELEM_W:0]  rem_d;
  logic                       last;

  always_comb begin
    dbl  = ecpa_pkg::fadd(acc_q, acc_q, m_i);
    addv = ecpa_pkg::fadd(acc_q, a_q, m_i);
    rem  = {acc_q, sh_q[ecpa_pkg::ELEM_W-1]};
    if (rem >= {1'b0, m_i}) begin
      rem_d = rem - {1'b0, m_i};
    end else begin
      rem_d = rem;
    end
    last = (cnt_q == ecpa_pkg::CNT_W'(ecpa_pkg::ELEM_W - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= 1'b0;
      op_q    <= ecpa_pkg::OP_MUL;
      cnt_q   <= '0;
      acc_q   <= '0;
      a_q     <= '0;
      sh_q    <= '0;
    end else begin
      done_q <= busy_q && last && (op_q == ecpa_pkg::OP_RED || phase_q);
      if (ctl_i.start && !busy_q) begin
        busy_q  <= 1'b1;
        op_q    <= ctl_i.op;
        a_q     <= a_i;
        sh_q    <= b_i;
        acc_q   <= '0;
        cnt_q   <= '0;
        phase_q <= 1'b0;
      end else if (busy_q) begin
        case (op_q)
          ecpa_pkg::OP_MUL: begin
            if (!phase_q) begin
              acc_q   <= dbl;
              phase_q <= 1'b1;
            end else begin
              if (sh_q[ecpa_pkg::ELEM_W-1]) begin
                acc_q <= addv;
              end
              sh_q    <= sh_q << 1;
              phase_q <= 1'b0;
              cnt_q   <= cnt_q + ecpa_pkg::CNT_W'(1);
              if (last) begin
                busy_q <= 1'b0;
              end
            end
          end
          ecpa_pkg::OP_RED: begin
            acc_q <= rem_d[ecpa_pkg::ELEM_W-1:0];
            sh_q  <= sh_q << 1;
            cnt_q <= cnt_q + ecpa_pkg::CNT_W'(1);
            if (last) begin
              busy_q <= 1'b0;
            end
          end
          default: begin
            busy_q <= 1'b0;
          end
        endcase
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

/* design/ecpa_cfg_regs.sv */
// apb register bank holding the field modulus and curve coefficient
module ecpa_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ecpa_pkg::CFG_AW-1:0] paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready,
  output ecpa_pkg::elem_t             prime_o,
  output ecpa_pkg::elem_t             coeff_o
);

  ecpa_pkg::elem_t prime_q;
  ecpa_pkg::elem_t coeff_q;
  logic            wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_q <= ecpa_pkg::P_RESET;
      coeff_q <= ecpa_pkg::ELEM_ZERO;
    end else if (wr_en) begin
      case (paddr[3])
        ecpa_pkg::REG_PRIME: prime_q <= pwdata[ecpa_pkg::ELEM_W-1:0];
        ecpa_pkg::REG_COEFF: coeff_q <= pwdata[ecpa_pkg::ELEM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      ecpa_pkg::REG_PRIME: prdata = 64'(prime_q);
      ecpa_pkg::REG_COEFF: prdata = 64'(coeff_q);
      default:             prdata = '0;
    endcase
  end

  assign prime_o = prime_q;
  assign coeff_o = coeff_q;

endmodule

/* design/ec_affine_point_add.sv */
// affine point add/subtract on a short weierstrass curve over gf(p)
// One beat in, one beat out. A beat is taken only while the sequencer is idle; the result
// waits in an output register, so the next beat can be taken while it is pending. All
// field multiplies and reductions run on one bit-serial unit: a multiply doubles and
// conditionally adds once per operand bit, a reduction takes one step per bit. An item
// reduces its four coordinates and the coefficient, then, for a finite non-opposite pair,
// runs (3 + S + W) multiplies, one more when doubling, where S is the bit length of p-2 and
// W its count of set bits;
// the modular inverse by exponentiation dominates the run time.
// Results with an infinite operand or opposite points come back after the reductions,
// and results with p below 2 come back without them.
module ec_affine_point_add (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        cmd_i,
  input  logic [63:0]                 px_i,
  input  logic [63:0]                 py_i,
  input  logic [63:0]                 qx_i,
  input  logic [63:0]                 qy_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [63:0]                 rx_o,
  output logic [63:0]                 ry_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ecpa_pkg::CFG_AW-1:0] paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready
);

  typedef enum logic [4:0] {
    S_IDLE, S_RED_PX, S_RED_PY, S_RED_QX, S_RED_QY, S_RED_A, S_CLASS,
    S_MUL_X2, S_DBL2, S_DBL3, S_INV_INIT, S_INV_CHK, S_INV_MR, S_INV_SQ,
    S_MUL_K, S_MUL_KK, S_X3B, S_PREP_Y, S_MUL_Y, S_OUT
  } state_e;

  state_e            state_q;
  logic              wait_q;
  logic              cmd_q;
  logic              out_valid_q;
  ecpa_pkg::elem_t   px_q, py_q, qx_q, qy_q, ca_q;
  ecpa_pkg::elem_t   num_q, den_q, inv_q, e_q, k_q, x3_q, y3_q, tmp_q;
  ecpa_pkg::elem_t   rx_q, ry_q;

  ecpa_pkg::elem_t   prime, coeff;
  ecpa_pkg::fu_ctl_t fu_ctl;
  ecpa_pkg::elem_t   fu_a, fu_b, fu_res;
  logic              fu_done;
  logic              op_state;
  ecpa_pkg::elem_t   neg_qy;

  ecpa_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .prime_o (prime),
    .coeff_o (coeff)
  );

  ecpa_field_unit u_fu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (fu_ctl),
    .a_i    (fu_a),
    .b_i    (fu_b),
    .m_i    (prime),
    .done_o (fu_done),
    .res_o  (fu_res)
  );

  always_comb begin
    op_state = 1'b1;
    fu_ctl.op = ecpa_pkg::OP_MUL;
    fu_a = ecpa_pkg::ELEM_ZERO;
    fu_b = ecpa_pkg::ELEM_ZERO;
    case (state_q)
      S_RED_PX: begin fu_ctl.op = ecpa_pkg::OP_RED; fu_b = px_q;  end
      S_RED_PY: begin fu_ctl.op = ecpa_pkg::OP_RED; fu_b = py_q;  end
      S_RED_QX: begin fu_ctl.op = ecpa_pkg::OP_RED; fu_b = qx_q;  end
      S_RED_QY: begin fu_ctl.op = ecpa_pkg::OP_RED; fu_b = qy_q;  end
      S_RED_A:  begin fu_ctl.op = ecpa_pkg::OP_RED; fu_b = coeff; end
      S_MUL_X2: begin fu_a = px_q;  fu_b = px_q;  end
      S_INV_MR: begin fu_a = inv_q; fu_b = den_q; end
      S_INV_SQ: begin fu_a = den_q; fu_b = den_q; end
      S_MUL_K:  begin fu_a = num_q; fu_b = inv_q; end
      S_MUL_KK: begin fu_a = k_q;   fu_b = k_q;   end
      S_MUL_Y:  begin fu_a = k_q;   fu_b = tmp_q; end
      default:  op_state = 1'b0;
    endcase
    fu_ctl.start = op_state && !wait_q;
  end

  assign neg_qy     = ecpa_pkg::fsub(ecpa_pkg::ELEM_ZERO, qy_q, prime);
  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wait_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cmd_q       <= 1'b0;
      px_q <= '0; py_q <= '0; qx_q <= '0; qy_q <= '0; ca_q <= '0;
      num_q <= '0; den_q <= '0; inv_q <= '0; e_q <= '0; k_q <= '0;
      x3_q <= '0; y3_q <= '0; tmp_q <= '0; rx_q <= '0; ry_q <= '0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      if (op_state) begin
        if (!wait_q) begin
          wait_q <= 1'b1;
        end else if (fu_done) begin
          wait_q <= 1'b0;
        end
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q <= cmd_i;
            px_q  <= px_i[ecpa_pkg::ELEM_W-1:0];
            py_q  <= py_i[ecpa_pkg::ELEM_W-1:0];
            qx_q  <= qx_i[ecpa_pkg::ELEM_W-1:0];
            qy_q  <= qy_i[ecpa_pkg::ELEM_W-1:0];
            if (prime < ecpa_pkg::ELEM_TWO) begin
              x3_q    <= ecpa_pkg::ELEM_ONE;
              y3_q    <= ecpa_pkg::ELEM_ZERO;
              state_q <= S_OUT;
            end else begin
              state_q <= S_RED_PX;
            end
          end
        end
        S_RED_PX: if (wait_q && fu_done) begin px_q <= fu_res; state_q <= S_RED_PY; end
        S_RED_PY: if (wait_q && fu_done) begin py_q <= fu_res; state_q <= S_RED_QX; end
        S_RED_QX: if (wait_q && fu_done) begin qx_q <= fu_res; state_q <= S_RED_QY; end
        S_RED_QY: begin
          if (wait_q && fu_done) begin
            qy_q    <= cmd_q ? ecpa_pkg::fsub(ecpa_pkg::ELEM_ZERO, fu_res, prime) : fu_res;
            state_q <= S_RED_A;
          end
        end
        S_RED_A: if (wait_q && fu_done) begin ca_q <= fu_res; state_q <= S_CLASS; end
        S_CLASS: begin
          if (px_q == ecpa_pkg::ELEM_ONE && py_q == ecpa_pkg::ELEM_ZERO) begin
            x3_q <= qx_q; y3_q <= qy_q; state_q <= S_OUT;
          end else if (qx_q == ecpa_pkg::ELEM_ONE && qy_q == ecpa_pkg::ELEM_ZERO) begin
            x3_q <= px_q; y3_q <= py_q; state_q <= S_OUT;
          end else if (px_q == qx_q && py_q == neg_qy) begin
            x3_q <= ecpa_pkg::ELEM_ONE; y3_q <= ecpa_pkg::ELEM_ZERO; state_q <= S_OUT;
          end else if (px_q == qx_q && py_q == qy_q) begin
            state_q <= S_MUL_X2;
          end else begin
            num_q   <= ecpa_pkg::fsub(qy_q, py_q, prime);
            den_q   <= ecpa_pkg::fsub(qx_q, px_q, prime);
            state_q <= S_INV_INIT;
          end
        end
        S_MUL_X2: begin
          if (wait_q && fu_done) begin
            tmp_q   <= fu_res;
            num_q   <= ecpa_pkg::fadd(fu_res, fu_res, prime);
            state_q <= S_DBL2;
          end
        end
        S_DBL2: begin
          num_q   <= ecpa_pkg::fadd(num_q, tmp_q, prime);
          state_q <= S_DBL3;
        end
        S_DBL3: begin
          num_q   <= ecpa_pkg::fadd(num_q, ca_q, prime);
          den_q   <= ecpa_pkg::fadd(py_q, py_q, prime);
          state_q <= S_INV_INIT;
        end
        S_INV_INIT: begin
          e_q     <= prime - ecpa_pkg::ELEM_TWO;
          inv_q   <= ecpa_pkg::ELEM_ONE;
          state_q <= S_INV_CHK;
        end
        S_INV_CHK: begin
          if (e_q == ecpa_pkg::ELEM_ZERO) begin
            state_q <= S_MUL_K;
          end else if (e_q[0]) begin
            state_q <= S_INV_MR;
          end else begin
            state_q <= S_INV_SQ;
          end
        end
        S_INV_MR: if (wait_q && fu_done) begin inv_q <= fu_res; state_q <= S_INV_SQ; end
        S_INV_SQ: begin
          if (wait_q && fu_done) begin
            den_q   <= fu_res;
            e_q     <= e_q >> 1;
            state_q <= S_INV_CHK;
          end
        end
        S_MUL_K: if (wait_q && fu_done) begin k_q <= fu_res; state_q <= S_MUL_KK; end
        S_MUL_KK: begin
          if (wait_q && fu_done) begin
            x3_q    <= ecpa_pkg::fsub(fu_res, px_q, prime);
            state_q <= S_X3B;
          end
        end
        S_X3B: begin
          x3_q    <= ecpa_pkg::fsub(x3_q, qx_q, prime);
          state_q <= S_PREP_Y;
        end
        S_PREP_Y: begin
          tmp_q   <= ecpa_pkg::fsub(px_q, x3_q, prime);
          state_q <= S_MUL_Y;
        end
        S_MUL_Y: begin
          if (wait_q && fu_done) begin
            y3_q    <= ecpa_pkg::fsub(fu_res, py_q, prime);
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            rx_q        <= x3_q;
            ry_q        <= y3_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign rx_o        = 64'(rx_q);
  assign ry_o        = 64'(ry_q);

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q != S_IDLE)
    else $error("accepted beat did not start the sequencer");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fu_done |=> !fu_done)
    else $error("field unit done held for more than one cycle");

  a_no_start_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wait_q && !fu_done |-> !fu_ctl.start)
    else $error("field unit restarted while an operation was in flight");

endmodule
